// ===== rtl/core/tsm_pkg.sv =====
// ----------------------------------------------------------------------------
// tsm_pkg
// Shared types and constants of the topological sort block.
// ----------------------------------------------------------------------------
`default_nettype none

package tsm_pkg;

  localparam int unsigned NODE_W        = 5;
  localparam int unsigned CFG_W         = 6;
  localparam int unsigned MAX_NODES_DEF = 32;

  typedef enum logic {
    OP_EDGE = 1'b0,
    OP_SORT = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SORT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic              edge_we;
    logic [NODE_W-1:0] from_node;
    logic [NODE_W-1:0] to_node;
    logic              start;
    logic              step;
    logic              clear;
  } cell_ctl_t;

  // Node indices are NODE_W bits wide, so at most 2**NODE_W cells are used.
  function automatic int unsigned cell_count(input int unsigned max_nodes);
    int unsigned lim;
    lim = 1 << NODE_W;
    return (max_nodes < lim) ? max_nodes : lim;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tsm_if.sv =====
// ----------------------------------------------------------------------------
// tsm_in_if / tsm_out_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsm_in_if;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [tsm_pkg::NODE_W-1:0] from_node;
  logic [tsm_pkg::NODE_W-1:0] to_node;

  modport source (output valid, output opcode, output from_node, output to_node,
                  input ready);
  modport sink   (input valid, input opcode, input from_node, input to_node,
                  output ready);
endinterface

interface tsm_out_if;
  logic                      valid;
  logic                      ready;
  logic [tsm_pkg::NODE_W-1:0] node_index;
  logic                      last;
  logic                      cycle_found;

  modport source (output valid, output node_index, output last, output cycle_found,
                  input ready);
  modport sink   (input valid, input node_index, input last, input cycle_found,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tsm_cell.sv =====
// ----------------------------------------------------------------------------
// tsm_cell
// One node of the graph: its predecessor row and emitted mark. Takes part in
// a lowest-index-first ripple that picks the next ready node.
// ----------------------------------------------------------------------------
`default_nettype none

module tsm_cell #(
  parameter int unsigned NumCells = 32,
  parameter int unsigned CellIdx  = 0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tsm_pkg::cell_ctl_t         ctl_i,
  input  logic [NumCells-1:0]        valid_i,
  input  logic [NumCells-1:0]        emitted_i,
  input  logic                       found_i,
  input  logic [tsm_pkg::NODE_W-1:0] idx_i,
  output logic                       found_o,
  output logic [tsm_pkg::NODE_W-1:0] idx_o,
  output logic                       emitted_o
);
  import tsm_pkg::*;

  localparam int unsigned IW = $clog2(NumCells);

  logic [NumCells-1:0] pred_q;
  logic                emitted_q;
  logic                ready;
  logic                sel;
  logic                hit_edge;

  assign ready = valid_i[CellIdx] & ~emitted_q & ~|(pred_q & valid_i & ~emitted_i);
  assign sel   = ready & ~found_i;

  assign found_o   = found_i | ready;
  assign idx_o     = sel ? NODE_W'(CellIdx) : idx_i;
  assign emitted_o = emitted_q;

  assign hit_edge = ctl_i.edge_we && (ctl_i.to_node == NODE_W'(CellIdx))
                    && ({1'b0, ctl_i.from_node} < (NODE_W+1)'(NumCells));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pred_q    <= '0;
      emitted_q <= 1'b0;
    end else if (ctl_i.clear) begin
      pred_q    <= '0;
      emitted_q <= 1'b0;
    end else begin
      if (ctl_i.start) begin
        emitted_q <= 1'b0;
      end else if (ctl_i.step && sel) begin
        emitted_q <= 1'b1;
      end
      if (hit_edge) begin
        pred_q[ctl_i.from_node[IW-1:0]] <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tsm_ctrl.sv =====
// ----------------------------------------------------------------------------
// tsm_ctrl
// Sequencer: edge loads, one sort step per cycle, order buffer and result
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tsm_ctrl #(
  parameter int unsigned NumCells = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [tsm_pkg::CFG_W-1:0]  cfg_data_i,
  tsm_in_if.sink                     in_i,
  tsm_out_if.source                  out_o,
  input  logic                       found_i,
  input  logic [tsm_pkg::NODE_W-1:0] idx_i,
  output tsm_pkg::cell_ctl_t         ctl_o,
  output logic [NumCells-1:0]        valid_o
);
  import tsm_pkg::*;

  localparam int unsigned IW = $clog2(NumCells);
  localparam int unsigned CW = $clog2(NumCells + 1);

  state_e            state_q, state_d;
  logic [CFG_W-1:0]  cfg_q;
  logic [CW-1:0]     n_act;
  logic [CW-1:0]     n_q;
  logic [CW-1:0]     cnt_q;
  logic [CW-1:0]     rd_q;
  logic              cycle_q;
  logic [NODE_W-1:0] order_q [NumCells];
  logic              ov_q;
  logic [NODE_W-1:0] node_q;
  logic              last_q;
  logic              cyc_q;

  logic              in_fire;
  logic              sort_done;
  logic              emit_load;
  logic              emit_last;

  assign in_fire   = in_i.valid & in_i.ready;
  assign sort_done = ~found_i | (cnt_q + CW'(1) == n_q);
  assign emit_last = cycle_q | (rd_q + CW'(1) == cnt_q);

  always_comb begin
    if (cfg_q == '0) begin
      n_act = CW'(1);
    end else if (cfg_q > CFG_W'(NumCells)) begin
      n_act = CW'(NumCells);
    end else begin
      n_act = cfg_q[CW-1:0];
    end
  end

  for (genvar i = 0; i < NumCells; i++) begin : g_valid
    assign valid_o[i] = CW'(i) < n_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && in_i.opcode == OP_SORT) state_d = ST_SORT;
      end
      ST_SORT: begin
        if (sort_done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_load && emit_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_i.ready      = 1'b0;
    emit_load       = 1'b0;
    ctl_o           = '0;
    ctl_o.from_node = in_i.from_node;
    ctl_o.to_node   = in_i.to_node;
    unique case (state_q)
      ST_IDLE: begin
        in_i.ready    = 1'b1;
        ctl_o.edge_we = in_fire && in_i.opcode == OP_EDGE;
        ctl_o.start   = in_fire && in_i.opcode == OP_SORT;
      end
      ST_SORT: begin
        ctl_o.step  = found_i;
        ctl_o.clear = sort_done;
      end
      ST_EMIT: begin
        emit_load = ~ov_q | out_o.ready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cfg_q   <= CFG_W'(1);
      n_q     <= CW'(1);
      cnt_q   <= '0;
      rd_q    <= '0;
      cycle_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) cfg_q <= cfg_data_i;
      if (ctl_o.start) begin
        n_q     <= n_act;
        cnt_q   <= '0;
        rd_q    <= '0;
        cycle_q <= 1'b0;
      end
      if (state_q == ST_SORT) begin
        if (found_i) cnt_q <= cnt_q + CW'(1);
        else         cycle_q <= 1'b1;
      end
      if (emit_load) begin
        ov_q <= 1'b1;
        rd_q <= rd_q + CW'(1);
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SORT && found_i) begin
      order_q[cnt_q[IW-1:0]] <= idx_i;
    end
    if (emit_load) begin
      node_q <= cycle_q ? '0 : order_q[rd_q[IW-1:0]];
      last_q <= emit_last;
      cyc_q  <= cycle_q;
    end
  end

  assign out_o.valid       = ov_q;
  assign out_o.node_index  = node_q;
  assign out_o.last        = last_q;
  assign out_o.cycle_found = cyc_q;

  a_sort_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SORT |-> cnt_q < n_q)
    else $error("sort count reached node count while sorting");

  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT && !cycle_q |-> rd_q < cnt_q)
    else $error("emit pointer past end of order");

  a_sort_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT && $past(state_q) == ST_SORT |-> cycle_q || cnt_q == n_q)
    else $error("sort ended with neither full order nor cycle");

  a_cycle_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && cyc_q |-> last_q && node_q == '0)
    else $error("cycle result not final or nonzero index");

endmodule

`default_nettype wire

// ===== rtl/core/topological_sort_matrix.sv =====
// ----------------------------------------------------------------------------
// topological_sort_matrix
// Kahn topological sort over an adjacency matrix held in a chain of node cells.
//
//   channel   dir  handshake       payload
//   in_i      in   valid/ready     opcode, from_node, to_node
//   out_o     out  valid/ready     node_index, last, cycle_found
//   cfg       in   cfg_we_i        cfg_data_i (node_count)
//
// Edge item: stored at the transfer edge. Sort item: the ripple through the
// cell chain picks one node a cycle into the order buffer; then one result
// per cycle leaves through the output register while out_o.ready is high.
// A cycle is detected when no ready node is left before all are emitted,
// and gives one result. in_i is not ready during sort and emit.
// Reset clears all matrix rows at once; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module topological_sort_matrix #(
  parameter int unsigned MaxNodes = tsm_pkg::MAX_NODES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [tsm_pkg::CFG_W-1:0] cfg_data_i,
  tsm_in_if.sink                    in_i,
  tsm_out_if.source                 out_o
);
  import tsm_pkg::*;

  localparam int unsigned NumCells = cell_count(MaxNodes);

  cell_ctl_t           ctl;
  logic [NumCells-1:0] valid;
  logic [NumCells-1:0] emitted;
  logic                found [NumCells+1];
  logic [NODE_W-1:0]   idx   [NumCells+1];

  assign found[0] = 1'b0;
  assign idx[0]   = '0;

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    tsm_cell #(
      .NumCells (NumCells),
      .CellIdx  (i)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .valid_i   (valid),
      .emitted_i (emitted),
      .found_i   (found[i]),
      .idx_i     (idx[i]),
      .found_o   (found[i+1]),
      .idx_o     (idx[i+1]),
      .emitted_o (emitted[i])
    );
  end

  tsm_ctrl #(
    .NumCells (NumCells)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .out_o      (out_o),
    .found_i    (found[NumCells]),
    .idx_i      (idx[NumCells]),
    .ctl_o      (ctl),
    .valid_o    (valid)
  );

endmodule

`default_nettype wire
